// ----- hw/rtl/ctsc_pkg.sv -----
// ----------------------------------------------------------------------------
// ctsc_pkg
// shared token kinds, character codes and classification helpers
// ----------------------------------------------------------------------------
package ctsc_pkg;

  typedef enum logic [4:0] {
    K_EOF     = 5'd0,
    K_IDENT   = 5'd1,
    K_NUMBER  = 5'd2,
    K_STRING  = 5'd3,
    K_CHAR    = 5'd4,
    K_KEYWORD = 5'd5,
    K_PLUS    = 5'd6,
    K_MINUS   = 5'd7,
    K_STAR    = 5'd8,
    K_SLASH   = 5'd9,
    K_EQ      = 5'd10,
    K_EQEQ    = 5'd11,
    K_NEQ     = 5'd12,
    K_LT      = 5'd13,
    K_LTE     = 5'd14,
    K_GT      = 5'd15,
    K_GTE     = 5'd16,
    K_AND     = 5'd17,
    K_OR      = 5'd18,
    K_NOT     = 5'd19,
    K_ASSIGN  = 5'd20,
    K_SEMI    = 5'd21,
    K_COMMA   = 5'd22,
    K_LPAREN  = 5'd23,
    K_RPAREN  = 5'd24,
    K_LBRACE  = 5'd25,
    K_RBRACE  = 5'd26,
    K_UNKNOWN = 5'd27
  } kind_e;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_DQUOT = 8'h22;
  localparam logic [7:0] CH_SQUOT = 8'h27;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_BAR   = 8'h7C;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_LBRC  = 8'h7B;
  localparam logic [7:0] CH_RBRC  = 8'h7D;

  localparam int unsigned KW_NUM = 9;
  localparam int unsigned KW_MAX_LEN = 6;

  // first byte in the low bits
  localparam logic [47:0] KW_WORD [KW_NUM] = '{
    48'h0000_0000_6669, 48'h0000_6573_6C65, 48'h0000_0072_6F66,
    48'h0065_6C69_6877, 48'h6E72_7574_6572, 48'h0000_0074_6E69,
    48'h0000_7261_6863, 48'h0000_6469_6F76, 48'h7463_7572_7473
  };
  localparam logic [2:0] KW_LEN [KW_NUM] = '{
    3'd2, 3'd4, 3'd3, 3'd5, 3'd6, 3'd3, 3'd4, 3'd4, 3'd6
  };

  function automatic logic is_alpha(logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || c == 8'h5F;
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic kw_match(logic [47:0] w, logic [2:0] len);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < KW_NUM; i++) begin
      if (w == KW_WORD[i] && len == KW_LEN[i]) hit = 1'b1;
    end
    return hit;
  endfunction

  function automatic kind_e punct_kind(logic [7:0] c);
    kind_e k;
    case (c)
      CH_PLUS:  k = K_PLUS;
      CH_MINUS: k = K_MINUS;
      CH_STAR:  k = K_STAR;
      CH_SEMI:  k = K_SEMI;
      CH_COMMA: k = K_COMMA;
      CH_LPAR:  k = K_LPAREN;
      CH_RPAR:  k = K_RPAREN;
      CH_LBRC:  k = K_LBRACE;
      CH_RBRC:  k = K_RBRACE;
      default:  k = K_UNKNOWN;
    endcase
    return k;
  endfunction

  function automatic kind_e single_op_kind(logic [7:0] h);
    kind_e k;
    case (h)
      CH_BANG: k = K_NOT;
      CH_EQ:   k = K_ASSIGN;
      CH_LT:   k = K_LT;
      CH_GT:   k = K_GT;
      default: k = K_UNKNOWN;
    endcase
    return k;
  endfunction

endpackage

// ----- hw/rtl/ctsc_if.sv -----
// ----------------------------------------------------------------------------
// ctsc_if
// source byte channel and token descriptor channel
// ----------------------------------------------------------------------------
interface ctsc_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] source_byte;

  modport source (output valid, output mode, output source_byte, input ready);
  modport sink (input valid, input mode, input source_byte, output ready);
endinterface

interface ctsc_tok_if #(
  parameter int unsigned OFFSET_WIDTH = 32,
  parameter int unsigned COUNT_WIDTH  = 16
);
  logic                    valid;
  logic                    ready;
  logic [4:0]              token_kind;
  logic [OFFSET_WIDTH-1:0] start_offset;
  logic [COUNT_WIDTH-1:0]  token_length;
  logic [COUNT_WIDTH-1:0]  line_number;
  logic [COUNT_WIDTH-1:0]  column_number;
  logic                    last_of_run;

  modport source (output valid, output token_kind, output start_offset,
                  output token_length, output line_number, output column_number,
                  output last_of_run, input ready);
  modport sink (input valid, input token_kind, input start_offset,
                input token_length, input line_number, input column_number,
                input last_of_run, output ready);
endinterface

// ----- hw/rtl/ctsc_scan.sv -----
// ----------------------------------------------------------------------------
// ctsc_scan
// scanner state and the per-beat update that yields up to three tokens
// ----------------------------------------------------------------------------
module ctsc_scan #(
  parameter int unsigned OFFSET_WIDTH = 32,
  parameter int unsigned COUNT_WIDTH  = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      acc_i,
  input  logic                      mode_i,
  input  logic [7:0]                byte_i,
  output logic [1:0]                res_cnt_o,
  output logic [3*(5+OFFSET_WIDTH+3*COUNT_WIDTH+1)-1:0] res_o
);
  import ctsc_pkg::*;

  localparam int unsigned OW = OFFSET_WIDTH;
  localparam int unsigned CW = COUNT_WIDTH;
  localparam logic [OW-1:0] OMAX = {OW{1'b1}};
  localparam logic [CW-1:0] CMAX = {CW{1'b1}};
  localparam logic [CW-1:0] C_ONE = CW'(1);

  typedef struct packed {
    logic [4:0]    kind;
    logic [OW-1:0] off;
    logic [CW-1:0] len;
    logic [CW-1:0] line;
    logic [CW-1:0] col;
    logic          last;
  } res_t;

  typedef enum logic [3:0] {
    PH_IDLE, PH_SLASH, PH_LINE, PH_BLOCK, PH_BSTAR, PH_IDENT, PH_NUM,
    PH_NDOT, PH_FRAC, PH_STR, PH_ESC, PH_OP
  } phase_e;

  phase_e        ph_q, ph_d;
  logic [7:0]    held_q, held_d;
  logic [CW-1:0] line_q, line_d, col_q, col_d;
  logic [OW-1:0] off_q, off_d, ts_q, ts_d, doff_q, doff_d;
  logic [CW-1:0] tl_q, tl_d, tc_q, tc_d, len_q, len_d, dcol_q, dcol_d;
  logic [47:0]   kw_q, kw_d;

  res_t       res [3];
  logic [1:0] n;
  logic       do_idle;
  logic       is_kw;
  kind_e      two;

  function automatic res_t mk(kind_e k, logic [OW-1:0] o, logic [CW-1:0] l,
                              logic [CW-1:0] ln, logic [CW-1:0] cl);
    res_t r;
    r.kind = k;
    r.off  = o;
    r.len  = l;
    r.line = ln;
    r.col  = cl;
    r.last = 1'b0;
    return r;
  endfunction

  function automatic logic [CW-1:0] csat(logic [CW-1:0] v);
    return (v == CMAX) ? v : v + C_ONE;
  endfunction

  always_comb begin
    ph_d = ph_q; held_d = held_q; line_d = line_q; col_d = col_q;
    off_d = off_q; ts_d = ts_q; tl_d = tl_q; tc_d = tc_q; len_d = len_q;
    kw_d = kw_q; doff_d = doff_q; dcol_d = dcol_q;
    n = 2'd0;
    do_idle = 1'b0;
    two = K_UNKNOWN;
    for (int i = 0; i < 3; i++) res[i] = '0;
    is_kw = (len_q <= CW'(KW_MAX_LEN)) && kw_match(kw_q, len_q[2:0]);

    if (acc_i) begin
      if (mode_i) begin
        case (ph_q)
          PH_SLASH: begin
            res[n] = mk(K_SLASH, ts_q, C_ONE, tl_q, tc_q); n = n + 2'd1;
          end
          PH_IDENT: begin
            res[n] = mk(is_kw ? K_KEYWORD : K_IDENT, ts_q, len_q, tl_q, tc_q);
            n = n + 2'd1;
          end
          PH_NUM, PH_FRAC: begin
            res[n] = mk(K_NUMBER, ts_q, len_q, tl_q, tc_q); n = n + 2'd1;
          end
          PH_NDOT: begin
            res[n] = mk(K_NUMBER, ts_q, len_q, tl_q, tc_q); n = n + 2'd1;
            res[n] = mk(K_UNKNOWN, doff_q, C_ONE, tl_q, dcol_q); n = n + 2'd1;
          end
          PH_STR, PH_ESC: begin
            res[n] = mk(K_UNKNOWN, ts_q, '0, line_q, col_q); n = n + 2'd1;
          end
          PH_OP: begin
            res[n] = mk(single_op_kind(held_q), ts_q, C_ONE, tl_q, tc_q);
            n = n + 2'd1;
          end
          default: ;
        endcase
        res[n] = mk(K_EOF, off_q, '0, line_q, col_q); n = n + 2'd1;
        ph_d = PH_IDLE; held_d = '0; line_d = C_ONE; col_d = C_ONE;
        off_d = '0; ts_d = '0; tl_d = C_ONE; tc_d = C_ONE; len_d = '0;
        kw_d = '0; doff_d = '0; dcol_d = '0;
      end else begin
        case (ph_q)
          PH_SLASH: begin
            if (byte_i == CH_SLASH) ph_d = PH_LINE;
            else if (byte_i == CH_STAR) ph_d = PH_BLOCK;
            else begin
              res[n] = mk(K_SLASH, ts_q, C_ONE, tl_q, tc_q); n = n + 2'd1;
              do_idle = 1'b1;
            end
          end
          PH_LINE: if (byte_i == CH_LF) ph_d = PH_IDLE;
          PH_BLOCK: if (byte_i == CH_STAR) ph_d = PH_BSTAR;
          PH_BSTAR: begin
            if (byte_i == CH_SLASH) ph_d = PH_IDLE;
            else if (byte_i != CH_STAR) ph_d = PH_BLOCK;
          end
          PH_IDENT: begin
            if (is_alpha(byte_i) || is_digit(byte_i)) begin
              for (int i = 0; i < KW_MAX_LEN; i++) begin
                if (len_q == CW'(i)) kw_d[8*i +: 8] = kw_q[8*i +: 8] | byte_i;
              end
              len_d = csat(len_q);
            end else begin
              res[n] = mk(is_kw ? K_KEYWORD : K_IDENT, ts_q, len_q, tl_q, tc_q);
              n = n + 2'd1;
              do_idle = 1'b1;
            end
          end
          PH_NUM: begin
            if (is_digit(byte_i)) len_d = csat(len_q);
            else if (byte_i == CH_DOT) begin
              doff_d = off_q; dcol_d = col_q; ph_d = PH_NDOT;
            end else begin
              res[n] = mk(K_NUMBER, ts_q, len_q, tl_q, tc_q); n = n + 2'd1;
              do_idle = 1'b1;
            end
          end
          PH_NDOT: begin
            if (is_digit(byte_i)) begin
              len_d = csat(csat(len_q)); ph_d = PH_FRAC;
            end else begin
              res[n] = mk(K_NUMBER, ts_q, len_q, tl_q, tc_q); n = n + 2'd1;
              res[n] = mk(K_UNKNOWN, doff_q, C_ONE, tl_q, dcol_q); n = n + 2'd1;
              do_idle = 1'b1;
            end
          end
          PH_FRAC: begin
            if (is_digit(byte_i)) len_d = csat(len_q);
            else begin
              res[n] = mk(K_NUMBER, ts_q, len_q, tl_q, tc_q); n = n + 2'd1;
              do_idle = 1'b1;
            end
          end
          PH_STR: begin
            if (byte_i == held_q) begin
              res[n] = mk((held_q == CH_DQUOT) ? K_STRING : K_CHAR, ts_q, len_q,
                          line_q, tc_q);
              n = n + 2'd1;
              ph_d = PH_IDLE;
            end else begin
              if (byte_i == CH_BSL) ph_d = PH_ESC;
              len_d = csat(len_q);
            end
          end
          PH_ESC: begin
            len_d = csat(len_q); ph_d = PH_STR;
          end
          PH_OP: begin
            if (byte_i == CH_EQ) begin
              if (held_q == CH_BANG) two = K_NEQ;
              else if (held_q == CH_EQ) two = K_EQEQ;
              else if (held_q == CH_LT) two = K_LTE;
              else if (held_q == CH_GT) two = K_GTE;
            end else if (byte_i == CH_AMP && held_q == CH_AMP) two = K_AND;
            else if (byte_i == CH_BAR && held_q == CH_BAR) two = K_OR;
            if (two != K_UNKNOWN) begin
              res[n] = mk(two, ts_q, CW'(2), tl_q, tc_q); n = n + 2'd1;
              ph_d = PH_IDLE;
            end else begin
              res[n] = mk(single_op_kind(held_q), ts_q, C_ONE, tl_q, tc_q);
              n = n + 2'd1;
              do_idle = 1'b1;
            end
          end
          default: do_idle = 1'b1;
        endcase

        if (do_idle) begin
          ph_d = PH_IDLE;
          if (byte_i == CH_SPACE || byte_i == CH_TAB || byte_i == CH_CR ||
              byte_i == CH_LF) begin
            ph_d = PH_IDLE;
          end else if (byte_i == CH_SLASH) begin
            ts_d = off_q; tl_d = line_q; tc_d = col_q; ph_d = PH_SLASH;
          end else if (is_alpha(byte_i)) begin
            ts_d = off_q; tl_d = line_q; tc_d = col_q; len_d = C_ONE;
            kw_d = {40'd0, byte_i}; ph_d = PH_IDENT;
          end else if (is_digit(byte_i)) begin
            ts_d = off_q; tl_d = line_q; tc_d = col_q; len_d = C_ONE;
            ph_d = PH_NUM;
          end else if (byte_i == CH_DQUOT || byte_i == CH_SQUOT) begin
            ts_d = (off_q == OMAX) ? off_q : off_q + OW'(1);
            tl_d = line_q; tc_d = csat(col_q); len_d = '0;
            held_d = byte_i; ph_d = PH_STR;
          end else if (byte_i == CH_BANG || byte_i == CH_EQ || byte_i == CH_LT ||
                       byte_i == CH_GT || byte_i == CH_AMP || byte_i == CH_BAR) begin
            ts_d = off_q; tl_d = line_q; tc_d = col_q; held_d = byte_i;
            ph_d = PH_OP;
          end else begin
            res[n] = mk(punct_kind(byte_i), off_q, C_ONE, line_q, col_q);
            n = n + 2'd1;
          end
        end

        off_d = (off_q == OMAX) ? off_q : off_q + OW'(1);
        if (byte_i == CH_LF) begin
          line_d = csat(line_q); col_d = C_ONE;
        end else begin
          col_d = csat(col_q);
        end
      end
    end
    if (n != 2'd0) res[n - 2'd1].last = 1'b1;
  end

  assign res_cnt_o = n;
  assign res_o = {res[2], res[1], res[0]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q <= PH_IDLE; held_q <= '0; line_q <= C_ONE; col_q <= C_ONE;
      off_q <= '0; ts_q <= '0; tl_q <= C_ONE; tc_q <= C_ONE; len_q <= '0;
      kw_q <= '0; doff_q <= '0; dcol_q <= '0;
    end else begin
      ph_q <= ph_d; held_q <= held_d; line_q <= line_d; col_q <= col_d;
      off_q <= off_d; ts_q <= ts_d; tl_q <= tl_d; tc_q <= tc_d; len_q <= len_d;
      kw_q <= kw_d; doff_q <= doff_d; dcol_q <= dcol_d;
    end
  end

endmodule

// ----- hw/rtl/ctsc_res_fifo.sv -----
// ----------------------------------------------------------------------------
// ctsc_res_fifo
// four-entry token queue taking up to three tokens per beat
// ----------------------------------------------------------------------------
module ctsc_res_fifo #(
  parameter int unsigned WIDTH = 82
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [1:0]         push_cnt_i,
  input  logic [3*WIDTH-1:0] push_data_i,
  output logic               room_o,
  output logic               valid_o,
  input  logic               ready_i,
  output logic [WIDTH-1:0]   data_o
);
  import ctsc_pkg::*;

  logic [WIDTH-1:0] mem_q [4];
  logic [1:0]       wptr_q, rptr_q;
  logic [2:0]       cnt_q;
  logic             pop;

  assign pop     = valid_o && ready_i;
  assign valid_o = (cnt_q != 3'd0);
  assign room_o  = (cnt_q <= 3'd1);
  assign data_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      if (2'(i) < push_cnt_i) mem_q[wptr_q + 2'(i)] <= push_data_i[WIDTH*i +: WIDTH];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_q + push_cnt_i;
      rptr_q <= rptr_q + {1'b0, pop};
      cnt_q  <= cnt_q + {1'b0, push_cnt_i} - {2'b0, pop};
    end
  end

endmodule

// ----- hw/rtl/c_like_token_scanner_core.sv -----
// ----------------------------------------------------------------------------
// c_like_token_scanner_core
// streaming scanner for a small c-like language
// ----------------------------------------------------------------------------
// Takes one source byte per beat and a final end beat, and emits token
// descriptors (kind, start offset, length, line, column). The tokens of a byte,
// at most three, enter a four-entry queue and leave one per cycle while the
// output is ready. Input is taken while the queue holds at most one token, so a
// stream giving one token per byte runs at one byte per cycle when the
// output is not stalled. The end beat flushes the open token, emits eof and
// returns the scanner to its reset state.
module c_like_token_scanner_core #(
  parameter int unsigned OFFSET_WIDTH = 32,
  parameter int unsigned COUNT_WIDTH  = 16
) (
  input logic            clk_i,
  input logic            rst_ni,
  ctsc_in_if.sink        src_i,
  ctsc_tok_if.source     tok_o
);
  import ctsc_pkg::*;

  localparam int unsigned RW = 5 + OFFSET_WIDTH + 3 * COUNT_WIDTH + 1;

  logic          acc;
  logic          room;
  logic [1:0]    res_cnt;
  logic [3*RW-1:0] res;
  logic [RW-1:0] head;

  assign src_i.ready = room;
  assign acc = src_i.valid && room;

  ctsc_scan #(
    .OFFSET_WIDTH(OFFSET_WIDTH),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_scan (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .acc_i    (acc),
    .mode_i   (src_i.mode),
    .byte_i   (src_i.source_byte),
    .res_cnt_o(res_cnt),
    .res_o    (res)
  );

  ctsc_res_fifo #(
    .WIDTH(RW)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_cnt_i (res_cnt),
    .push_data_i(res),
    .room_o     (room),
    .valid_o    (tok_o.valid),
    .ready_i    (tok_o.ready),
    .data_o     (head)
  );

  assign {tok_o.token_kind, tok_o.start_offset, tok_o.token_length,
          tok_o.line_number, tok_o.column_number, tok_o.last_of_run} = head;

endmodule

// ----- hw/rtl/ctsc_checker.sv -----
// ----------------------------------------------------------------------------
// ctsc_checker
// port-level checks on the token scanner
// ----------------------------------------------------------------------------
module ctsc_checker #(
  parameter int unsigned OFFSET_WIDTH = 32,
  parameter int unsigned COUNT_WIDTH  = 16
) (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    out_valid_i,
  input logic                    out_ready_i,
  input logic [4:0]              kind_i,
  input logic [OFFSET_WIDTH-1:0] offset_i,
  input logic [COUNT_WIDTH-1:0]  length_i,
  input logic [COUNT_WIDTH-1:0]  line_i,
  input logic [COUNT_WIDTH-1:0]  column_i,
  input logic                    last_i
);
  import ctsc_pkg::*;

  // a stalled beat holds its kind, offset, length and last flag
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(kind_i) &&
      $stable(offset_i) && $stable(length_i) && $stable(last_i))
    else $error("stalled token changed");

  // eof closes its run and has no length
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && kind_i == K_EOF |-> last_i && length_i == '0)
    else $error("malformed eof token");

  // positions count from one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> line_i != '0 && column_i != '0)
    else $error("zero line or column");

  // only token classes the scanner produces
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> kind_i <= K_UNKNOWN && kind_i != K_EQ)
    else $error("token kind out of range");

endmodule

bind c_like_token_scanner_core ctsc_checker #(
  .OFFSET_WIDTH(OFFSET_WIDTH),
  .COUNT_WIDTH (COUNT_WIDTH)
) u_ctsc_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid_i(tok_o.valid),
  .out_ready_i(tok_o.ready),
  .kind_i     (tok_o.token_kind),
  .offset_i   (tok_o.start_offset),
  .length_i   (tok_o.token_length),
  .line_i     (tok_o.line_number),
  .column_i   (tok_o.column_number),
  .last_i     (tok_o.last_of_run)
);

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// token scanner testbench: source bytes in, token descriptors checked
// ----------------------------------------------------------------------------
// Feeds directed and random byte streams with end beats into the scanner,
// predicts the tokens of each beat with a behavioural scanner model and
// compares every token beat field by field, in order, with random stalls on
// both channels.
module tb_top;
  import ctsc_pkg::*;

  localparam int unsigned OW = 32;
  localparam int unsigned CW = 16;
  localparam logic [OW-1:0] OFF_MAX = '1;
  localparam logic [CW-1:0] CNT_MAX = '1;
  localparam int unsigned CYCLE_LIMIT = 200000;

  typedef enum logic [3:0] {
    S_IDLE, S_SLASH, S_LINE, S_BLOCK, S_BSTAR, S_IDENT, S_NUM, S_NDOT, S_FRAC,
    S_STR, S_ESC, S_OP
  } scan_e;

  typedef struct packed {
    logic       mode;
    logic [7:0] ch;
  } src_beat_t;

  typedef struct packed {
    kind_e          kind;
    logic [OW-1:0]  offset;
    logic [CW-1:0]  length;
    logic [CW-1:0]  line;
    logic [CW-1:0]  column;
    logic           last;
  } token_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  ctsc_in_if src_if ();
  ctsc_tok_if #(.OFFSET_WIDTH(OW), .COUNT_WIDTH(CW)) tok_if ();

  c_like_token_scanner_core #(.OFFSET_WIDTH(OW), .COUNT_WIDTH(CW)) DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .src_i  (src_if.sink),
    .tok_o  (tok_if.source)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // scanner state of the prediction
  scan_e         sc_phase;
  logic [7:0]    sc_held;
  logic [CW-1:0] sc_line, sc_col, sc_tline, sc_tcol, sc_len;
  logic [OW-1:0] sc_off, sc_tstart, sc_dot_off;
  logic [CW-1:0] sc_dot_col;
  logic [47:0]   sc_window;

  src_beat_t pending_beats[$];
  token_t    expected_tokens[$];
  int        mismatches = 0;
  int        cycles = 0;
  bit        stim_done = 1'b0;
  bit        calm = 1'b0;
  bit        hold_src = 1'b0;
  int        src_gap = 0, snk_gap = 0;

  function automatic logic [CW-1:0] cnt_inc(logic [CW-1:0] v);
    return (v == CNT_MAX) ? v : v + 1'b1;
  endfunction

  function automatic logic [OW-1:0] off_inc(logic [OW-1:0] v);
    return (v == OFF_MAX) ? v : v + 1'b1;
  endfunction

  function automatic bit letter(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic bit digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit kw_hit(logic [47:0] w, logic [CW-1:0] n);
    string words[9];
    logic [47:0] p;
    words = '{"if", "else", "for", "while", "return", "int", "char", "void", "struct"};
    if (n > 6) return 1'b0;
    foreach (words[i]) begin
      p = '0;
      for (int k = 0; k < words[i].len(); k++) p[8*k +: 8] = words[i][k];
      if (words[i].len() == n && p == w) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic kind_e lone_op(logic [7:0] h);
    case (h)
      "!":     return K_NOT;
      "=":     return K_ASSIGN;
      "<":     return K_LT;
      ">":     return K_GT;
      default: return K_UNKNOWN;
    endcase
  endfunction

  task automatic add_token(inout token_t run[$], input kind_e k, input logic [OW-1:0] o,
                           input logic [CW-1:0] n, input logic [CW-1:0] ln,
                           input logic [CW-1:0] col);
    token_t t;
    t = '{kind: k, offset: o, length: n, line: ln, column: col, last: 1'b0};
    if (run.size() < 3) run.push_back(t);
  endtask

  task automatic scanner_reset();
    sc_phase = S_IDLE; sc_held = '0; sc_line = CW'(1); sc_col = CW'(1); sc_off = '0;
    sc_tstart = '0; sc_tline = CW'(1); sc_tcol = CW'(1); sc_len = '0; sc_window = '0;
    sc_dot_off = '0; sc_dot_col = '0;
  endtask

  task automatic take_start();
    sc_tstart = sc_off; sc_tline = sc_line; sc_tcol = sc_col;
  endtask

  task automatic fresh_byte(inout token_t run[$], input logic [7:0] c);
    kind_e k;
    sc_phase = S_IDLE;
    if (c == " " || c == 8'h09 || c == 8'h0D || c == 8'h0A) return;
    if (c == "/") begin
      take_start(); sc_phase = S_SLASH;
    end else if (letter(c)) begin
      take_start(); sc_len = CW'(1); sc_window = {40'd0, c}; sc_phase = S_IDENT;
    end else if (digit(c)) begin
      take_start(); sc_len = CW'(1); sc_phase = S_NUM;
    end else if (c == 8'h22 || c == 8'h27) begin
      sc_tstart = off_inc(sc_off); sc_tline = sc_line; sc_tcol = cnt_inc(sc_col);
      sc_len = '0; sc_held = c; sc_phase = S_STR;
    end else if (c == "!" || c == "=" || c == "<" || c == ">" || c == "&" || c == "|") begin
      take_start(); sc_held = c; sc_phase = S_OP;
    end else begin
      case (c)
        "+":     k = K_PLUS;
        "-":     k = K_MINUS;
        "*":     k = K_STAR;
        ";":     k = K_SEMI;
        ",":     k = K_COMMA;
        "(":     k = K_LPAREN;
        ")":     k = K_RPAREN;
        "{":     k = K_LBRACE;
        "}":     k = K_RBRACE;
        default: k = K_UNKNOWN;
      endcase
      add_token(run, k, sc_off, CW'(1), sc_line, sc_col);
    end
  endtask

  task automatic word_token(inout token_t run[$]);
    add_token(run, kw_hit(sc_window, sc_len) ? K_KEYWORD : K_IDENT, sc_tstart, sc_len,
              sc_tline, sc_tcol);
  endtask

  task automatic predict_beat(input src_beat_t b);
    token_t run[$];
    logic [7:0] c;
    kind_e two;
    c = b.ch;
    if (b.mode) begin
      case (sc_phase)
        S_SLASH: add_token(run, K_SLASH, sc_tstart, CW'(1), sc_tline, sc_tcol);
        S_IDENT: word_token(run);
        S_NUM, S_FRAC: add_token(run, K_NUMBER, sc_tstart, sc_len, sc_tline, sc_tcol);
        S_NDOT: begin
          add_token(run, K_NUMBER, sc_tstart, sc_len, sc_tline, sc_tcol);
          add_token(run, K_UNKNOWN, sc_dot_off, CW'(1), sc_tline, sc_dot_col);
        end
        S_STR, S_ESC: add_token(run, K_UNKNOWN, sc_tstart, CW'(0), sc_line, sc_col);
        S_OP: add_token(run, lone_op(sc_held), sc_tstart, CW'(1), sc_tline, sc_tcol);
        default: ;
      endcase
      add_token(run, K_EOF, sc_off, CW'(0), sc_line, sc_col);
      scanner_reset();
    end else begin
      case (sc_phase)
        S_SLASH:
          if (c == "/") sc_phase = S_LINE;
          else if (c == "*") sc_phase = S_BLOCK;
          else begin
            add_token(run, K_SLASH, sc_tstart, CW'(1), sc_tline, sc_tcol);
            fresh_byte(run, c);
          end
        S_LINE: if (c == 8'h0A) sc_phase = S_IDLE;
        S_BLOCK: if (c == "*") sc_phase = S_BSTAR;
        S_BSTAR:
          if (c == "/") sc_phase = S_IDLE;
          else if (c != "*") sc_phase = S_BLOCK;
        S_IDENT:
          if (letter(c) || digit(c)) begin
            if (sc_len < 6) sc_window[8*sc_len +: 8] = c;
            sc_len = cnt_inc(sc_len);
          end else begin
            word_token(run);
            fresh_byte(run, c);
          end
        S_NUM:
          if (digit(c)) sc_len = cnt_inc(sc_len);
          else if (c == ".") begin
            sc_dot_off = sc_off; sc_dot_col = sc_col; sc_phase = S_NDOT;
          end else begin
            add_token(run, K_NUMBER, sc_tstart, sc_len, sc_tline, sc_tcol);
            fresh_byte(run, c);
          end
        S_NDOT:
          if (digit(c)) begin
            sc_len = cnt_inc(cnt_inc(sc_len)); sc_phase = S_FRAC;
          end else begin
            add_token(run, K_NUMBER, sc_tstart, sc_len, sc_tline, sc_tcol);
            add_token(run, K_UNKNOWN, sc_dot_off, CW'(1), sc_tline, sc_dot_col);
            fresh_byte(run, c);
          end
        S_FRAC:
          if (digit(c)) sc_len = cnt_inc(sc_len);
          else begin
            add_token(run, K_NUMBER, sc_tstart, sc_len, sc_tline, sc_tcol);
            fresh_byte(run, c);
          end
        S_STR:
          if (c == sc_held) begin
            add_token(run, (sc_held == 8'h22) ? K_STRING : K_CHAR, sc_tstart, sc_len,
                      sc_line, sc_tcol);
            sc_phase = S_IDLE;
          end else begin
            if (c == 8'h5C) sc_phase = S_ESC;
            sc_len = cnt_inc(sc_len);
          end
        S_ESC: begin
          sc_len = cnt_inc(sc_len); sc_phase = S_STR;
        end
        S_OP: begin
          two = K_UNKNOWN;
          if (c == "=") begin
            case (sc_held)
              "!": two = K_NEQ;
              "=": two = K_EQEQ;
              "<": two = K_LTE;
              ">": two = K_GTE;
              default: ;
            endcase
          end else if (c == "&" && sc_held == "&") two = K_AND;
          else if (c == "|" && sc_held == "|") two = K_OR;
          if (two != K_UNKNOWN) begin
            add_token(run, two, sc_tstart, CW'(2), sc_tline, sc_tcol);
            sc_phase = S_IDLE;
          end else begin
            add_token(run, lone_op(sc_held), sc_tstart, CW'(1), sc_tline, sc_tcol);
            fresh_byte(run, c);
          end
        end
        default: fresh_byte(run, c);
      endcase
      sc_off = off_inc(sc_off);
      if (c == 8'h0A) begin
        sc_line = cnt_inc(sc_line); sc_col = CW'(1);
      end else begin
        sc_col = cnt_inc(sc_col);
      end
    end
    if (run.size() > 0) run[run.size()-1].last = 1'b1;
    foreach (run[i]) expected_tokens.push_back(run[i]);
  endtask

  // stimulus helpers
  task automatic put_text(string s);
    foreach (s[i]) pending_beats.push_back('{mode: 1'b0, ch: s[i]});
  endtask

  task automatic put_end();
    pending_beats.push_back('{mode: 1'b1, ch: 8'($urandom)});
  endtask

  function automatic string random_lexeme();
    string pool[] = '{"if", "else", "for", "while", "return", "int", "char", "void",
                      "struct", "iff", "structs", "x_9", "Abc", "42", "3.14", "7.", "0",
                      "\"ab\\\"c\"", "'\\n'", "'x'", "==", "!=", "<=", ">=", "&&", "||",
                      "!", "=", "<", ">", "&", "|", "+", "-", "*", "/", ";", ",", "(",
                      ")", "{", "}", "// note\n", "/* c ** */", " ", "\n", "\t", "\r"};
    string s;
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) begin
      s = " ";
      s[0] = 8'($urandom);
      return s;
    end
    return pool[$urandom_range(0, pool.size() - 1)];
  endfunction

  initial begin
    scanner_reset();
    put_text("if else for while return int char void struct iff returns x");
    put_text("\n3.5 7.a 12. \"q\\\"\" 'c' == != <= >= && || ! = < > & | + - * / ;");
    put_text(",(){}");
    pending_beats.push_back('{mode: 1'b0, ch: 8'h00});
    pending_beats.push_back('{mode: 1'b0, ch: 8'hFF});
    pending_beats.push_back('{mode: 1'b0, ch: 8'h0B});
    put_text(" /* open");
    put_end();
    put_text("\"unterminated");
    put_end();
    put_text("9.");
    put_end();
    put_end();
    while (pending_beats.size() < 270) begin
      if ($urandom_range(0, 29) == 0) put_end();
      else put_text(random_lexeme());
    end
    put_end();
  end

  // source driver
  always @(posedge clk_i or negedge rst_ni) begin
    src_beat_t b;
    if (!rst_ni) begin
      src_if.valid <= 1'b0;
      src_if.mode <= 1'b0;
      src_if.source_byte <= '0;
    end else begin
      if (src_if.valid && src_if.ready) begin
        predict_beat('{mode: src_if.mode, ch: src_if.source_byte});
        void'(pending_beats.pop_front());
      end
      calm = pending_beats.size() < 40;
      if (src_gap > 0) src_gap--;
      else if (!calm && $urandom_range(0, 9) == 0) src_gap = $urandom_range(1, 12);
      hold_src = (pending_beats.size() == 150) && (expected_tokens.size() != 0);
      // a waiting beat stays on the channel until taken
      if (!src_if.valid || src_if.ready) begin
        if (pending_beats.size() != 0 && src_gap == 0 && !hold_src) begin
          b = pending_beats[0];
          src_if.valid <= 1'b1;
          src_if.mode <= b.mode;
          src_if.source_byte <= b.ch;
        end else begin
          src_if.valid <= 1'b0;
          if (pending_beats.size() == 0) stim_done = 1'b1;
        end
      end
    end
  end

  // token monitor
  always @(posedge clk_i or negedge rst_ni) begin
    token_t got, want;
    if (!rst_ni) begin
      tok_if.ready <= 1'b0;
    end else begin
      if (tok_if.valid && tok_if.ready) begin
        got = '{kind: kind_e'(tok_if.token_kind), offset: tok_if.start_offset,
                length: tok_if.token_length, line: tok_if.line_number,
                column: tok_if.column_number, last: tok_if.last_of_run};
        if (expected_tokens.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected token beat %p", got);
        end else begin
          want = expected_tokens.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) $display("token mismatch: expected %p, got %p", want, got);
          end
        end
      end
      if (snk_gap > 0) snk_gap--;
      else if (!calm && $urandom_range(0, 9) == 0) snk_gap = $urandom_range(1, 12);
      tok_if.ready <= (snk_gap == 0);
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (stim_done && expected_tokens.size() == 0);
    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && expected_tokens.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
